// ----- rtl/rfid_frame_tag_matcher_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RFID frame tag matcher
// Clocked, reset-qualified assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RFID_FRAME_TAG_MATCHER_TOP_ASSERT_SVH
`define RFID_FRAME_TAG_MATCHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFID_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rfid_pkg.sv -----
// ----------------------------------------------------------------------------
// RFID frame tag matcher package
// Shared types and fixed constants of the frame matcher.
// ----------------------------------------------------------------------------
package rfid_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [47:0] half_t;
	typedef logic [63:0] apb_data_t;
	typedef logic [5:0]  apb_addr_t;
	typedef logic [2:0]  reg_idx_t;
	typedef logic [3:0]  char_cnt_t;
	typedef logic [1:0]  code_t;

	localparam byte_t     START_BYTE     = 8'h02;
	localparam byte_t     END_BYTE       = 8'h03;
	localparam int        CODE_LEN       = 12;
	localparam int        CHARS_PER_HALF = 6;
	localparam int        NUM_REGS       = 6;
	localparam int        HALF_W         = 48;
	localparam code_t     NO_TAG         = 2'd3;
	localparam code_t     CODE_NONE      = 2'd0;

	// Register indexes, taken from paddr[5:3].
	localparam reg_idx_t REG_TAG0_FIRST  = 3'd0;
	localparam reg_idx_t REG_TAG0_SECOND = 3'd1;
	localparam reg_idx_t REG_TAG1_FIRST  = 3'd2;
	localparam reg_idx_t REG_TAG1_SECOND = 3'd3;
	localparam reg_idx_t REG_TAG2_FIRST  = 3'd4;
	localparam reg_idx_t REG_TAG2_SECOND = 3'd5;

endpackage

// ----- rtl/rfid_cell.sv -----
// ----------------------------------------------------------------------------
// RFID character cell
// Holds one character of the frame, passes it on, and compares it with tags.
// ----------------------------------------------------------------------------
module rfid_cell #(
	parameter int NUM_TAGS = 3
) (
	input  logic                  clk,
	input  logic                  shift_en,
	input  rfid_pkg::byte_t       din,
	input  rfid_pkg::byte_t       tag_byte [NUM_TAGS],
	output rfid_pkg::byte_t       dout,
	output logic [NUM_TAGS-1:0]   eq
);
	import rfid_pkg::*;

	byte_t char_q;

	// Payload register: no reset, every entry is written before a compare.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			char_q <= din;
		end
	end

	assign dout = char_q;

	always_comb begin
		for (int t = 0; t < NUM_TAGS; t++) begin
			eq[t] = (char_q == tag_byte[t]);
		end
	end

endmodule

// ----- rtl/rfid_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// RFID tag register file
// APB-style register port holding the six 48-bit halves of the allowed tags.
// ----------------------------------------------------------------------------
module rfid_cfg_regs (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  rfid_pkg::apb_addr_t                       paddr,
	input  rfid_pkg::apb_data_t                       pwdata,
	output rfid_pkg::apb_data_t                       prdata,
	output logic                                      pready,
	output rfid_pkg::half_t [rfid_pkg::NUM_REGS-1:0]  tag_regs
);
	import rfid_pkg::*;

	half_t [NUM_REGS-1:0] tag_q;
	reg_idx_t             idx;
	logic                 wr_en;
	half_t                rd_val;

	assign idx    = paddr[5:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_TAG0_FIRST:  tag_q[0] <= pwdata[HALF_W-1:0];
				REG_TAG0_SECOND: tag_q[1] <= pwdata[HALF_W-1:0];
				REG_TAG1_FIRST:  tag_q[2] <= pwdata[HALF_W-1:0];
				REG_TAG1_SECOND: tag_q[3] <= pwdata[HALF_W-1:0];
				REG_TAG2_FIRST:  tag_q[4] <= pwdata[HALF_W-1:0];
				REG_TAG2_SECOND: tag_q[5] <= pwdata[HALF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TAG0_FIRST:  rd_val = tag_q[0];
			REG_TAG0_SECOND: rd_val = tag_q[1];
			REG_TAG1_FIRST:  rd_val = tag_q[2];
			REG_TAG1_SECOND: rd_val = tag_q[3];
			REG_TAG2_FIRST:  rd_val = tag_q[4];
			REG_TAG2_SECOND: rd_val = tag_q[5];
			default:         rd_val = '0;
		endcase
	end

	assign prdata   = {16'h0000, rd_val};
	assign tag_regs = tag_q;

endmodule

// ----- rtl/rfid_frame_tag_matcher_top.sv -----
// ----------------------------------------------------------------------------
// RFID frame tag matcher: every received byte yields one match code transaction.
// Output valid is registered and rises in the cycle after input accept. Throughput is
// one byte per cycle, set by the single output register, unless a result is stalled.
// Reset clears frame state and tag registers and sets the last reported tag to none.
// ----------------------------------------------------------------------------
`include "rfid_frame_tag_matcher_top_assert.svh"

module rfid_frame_tag_matcher_top #(
	parameter int NUM_TAGS = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input channel: one received byte per transaction.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rfid_pkg::byte_t      rx_byte,
	// Output channel: one match code per input transaction.
	output logic                 out_valid,
	input  logic                 out_stall,
	output rfid_pkg::code_t      match_code,
	// Configuration port.
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  rfid_pkg::apb_addr_t  paddr,
	input  rfid_pkg::apb_data_t  pwdata,
	output rfid_pkg::apb_data_t  prdata,
	output logic                 pready
);
	import rfid_pkg::*;

	// The characters of a frame shift through a chain of twelve cells. A new
	// character enters the last cell, so after twelve stores cell 0 holds the
	// first character of the tag. Each cell compares its own character with
	// the matching character of every allowed tag; the per-tag results are
	// then combined across the chain to find a full match.

	half_t [NUM_REGS-1:0]  tag_regs;
	byte_t                 chain [CODE_LEN+1];
	logic [NUM_TAGS-1:0]   cell_eq [CODE_LEN];

	logic       in_frame_q;
	char_cnt_t  count_q;
	code_t      last_q;
	logic       out_valid_q;
	code_t      match_code_q;

	logic                 accept;
	logic                 store;
	logic                 finish;
	logic [NUM_TAGS-1:0]  tag_eq;
	logic                 found;
	code_t                code_c;
	code_t                next_last;

	rfid_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.tag_regs (tag_regs)
	);

	// The output register parts the two sides: a new byte is taken unless a
	// finished result is still held and the consumer stalls it.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Inside a frame, any byte but the end byte is stored until twelve are
	// held. The byte after the twelfth closes the frame whatever its value;
	// an end byte arriving earlier aborts it.
	assign store  = in_frame_q && (rx_byte != END_BYTE) && (count_q < char_cnt_t'(CODE_LEN));
	assign finish = in_frame_q && !store && (count_q == char_cnt_t'(CODE_LEN));

	assign chain[CODE_LEN] = rx_byte;

	for (genvar k = 0; k < CODE_LEN; k++) begin : g_cell
		localparam int HALF_SEL = k / CHARS_PER_HALF;
		localparam int POS      = k % CHARS_PER_HALF;
		localparam int LSB      = (CHARS_PER_HALF - 1 - POS) * 8;

		byte_t tag_byte [NUM_TAGS];

		for (genvar t = 0; t < NUM_TAGS; t++) begin : g_tag
			assign tag_byte[t] = tag_regs[2*t + HALF_SEL][LSB +: 8];
		end

		rfid_cell #(
			.NUM_TAGS (NUM_TAGS)
		) u_cell (
			.clk      (clk),
			.shift_en (accept && store),
			.din      (chain[k+1]),
			.tag_byte (tag_byte),
			.dout     (chain[k]),
			.eq       (cell_eq[k])
		);
	end

	// A tag matches when every cell agrees with it.
	always_comb begin
		for (int t = 0; t < NUM_TAGS; t++) begin
			tag_eq[t] = 1'b1;
			for (int k = 0; k < CODE_LEN; k++) begin
				tag_eq[t] = tag_eq[t] && cell_eq[k][t];
			end
		end
	end

	// The first matching tag that is not the one reported last wins.
	always_comb begin
		found     = 1'b0;
		code_c    = CODE_NONE;
		next_last = last_q;
		if (finish) begin
			for (int t = 0; t < NUM_TAGS; t++) begin
				if (!found && tag_eq[t] && (code_t'(t) != last_q)) begin
					found     = 1'b1;
					code_c    = code_t'(t + 1);
					next_last = code_t'(t);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			last_q     <= NO_TAG;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (rx_byte == START_BYTE) begin
					in_frame_q <= 1'b1;
					count_q    <= '0;
				end
			end else if (store) begin
				count_q <= count_q + char_cnt_t'(1);
			end else begin
				in_frame_q <= 1'b0;
			end
			last_q <= next_last;
		end
	end

	// Output register: a held result stays until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			match_code_q <= code_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign match_code = match_code_q;

	// The character count never runs past a full tag.
	`RFID_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1, count_q <= char_cnt_t'(CODE_LEN),
		"character count exceeds tag length")

	// A reported match becomes the last reported tag.
	`RFID_ASSERT_NEXT(a_last_follows, clk, arst_n, accept && (code_c != CODE_NONE),
		(last_q == match_code_q - code_t'(1)) && out_valid_q,
		"last reported tag does not follow the reported match")

	// A start byte outside a frame opens a new, empty frame.
	`RFID_ASSERT_NEXT(a_frame_open, clk, arst_n, accept && !in_frame_q && (rx_byte == START_BYTE),
		in_frame_q && (count_q == '0), "start byte did not open an empty frame")

endmodule
